>>> hw/rtl/sspu_pkg.sv
// shared types, codes and constants of the stepper station positioner
// no dependencies; imported by the interfaces and every module
package sspu_pkg;

    localparam int NUM_SEGMENTS = 13;
    localparam int STEP_W       = 16;
    localparam int STA_W        = 4;

    localparam logic [STEP_W-1:0] HOMING_STEPS = 16'hFFFF;

    localparam logic [STEP_W-1:0] SEG_DEFAULTS [NUM_SEGMENTS] = '{
        16'd880, 16'd635, 16'd675, 16'd675, 16'd660, 16'd675, 16'd675,
        16'd675, 16'd675, 16'd675, 16'd645, 16'd675, 16'd675
    };

    typedef enum logic [1:0] {
        ACT_MOVE  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_BUMP  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        action;
        logic [STA_W-1:0]  target_station;
        logic [STA_W-1:0]  table_index;
        logic [STEP_W-1:0] segment_steps;
    } t_item;

    typedef struct packed {
        logic             step_pulse;
        logic             reverse_dir;
        logic             motor_release;
        logic [STA_W-1:0] station;
        logic             moving;
        logic [1:0]       status_code;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [STA_W-1:0]  idx;
        logic [STEP_W-1:0] data;
    } t_tbl_wr;

endpackage

>>> hw/rtl/sspu_if.sv
// valid/ready channel interfaces for input items and result items
// depends on sspu_pkg for field widths
interface sspu_in_if
    import sspu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [STA_W-1:0]  target_station;
    logic [STA_W-1:0]  table_index;
    logic [STEP_W-1:0] segment_steps;

    modport source (output valid, action, target_station, table_index, segment_steps,
                    input ready);
    modport sink   (input valid, action, target_station, table_index, segment_steps,
                    output ready);
endinterface

interface sspu_out_if
    import sspu_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             step_pulse;
    logic             reverse_dir;
    logic             motor_release;
    logic [STA_W-1:0] station;
    logic             moving;
    logic [1:0]       status_code;

    modport source (output valid, step_pulse, reverse_dir, motor_release, station, moving,
                    status_code, input ready);
    modport sink   (input valid, step_pulse, reverse_dir, motor_release, station, moving,
                    status_code, output ready);
endinterface

>>> hw/rtl/sspu_table.sv
// per-segment step count table, reset to the default distances
// depends on sspu_pkg
module sspu_table
    import sspu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_wr           i_wr,
    input  logic [STA_W-1:0]  i_rd_idx,
    output logic [STEP_W-1:0] o_rd_data
);

    logic [STEP_W-1:0] r_tbl [NUM_SEGMENTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SEGMENTS; i++) begin
                r_tbl[i] <= SEG_DEFAULTS[i];
            end
        end else if (i_wr.en) begin
            r_tbl[i_wr.idx] <= i_wr.data;
        end
    end

    assign o_rd_data = (i_rd_idx < STA_W'(NUM_SEGMENTS)) ? r_tbl[i_rd_idx] : '0;

endmodule

>>> hw/rtl/sspu_ctrl.sv
// positioner state and per-item decision logic
// depends on sspu_pkg; reads segment lengths from sspu_table
module sspu_ctrl
    import sspu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  t_item             i_item,
    input  logic [STEP_W-1:0] i_seg_data,
    output logic [STA_W-1:0]  o_seg_idx,
    output t_tbl_wr           o_tbl_wr,
    output t_result           o_res
);

    logic              r_moving, n_moving;
    logic [STA_W-1:0]  r_station, n_station;
    logic [STA_W-1:0]  r_goal, n_goal;
    logic              r_reverse, n_reverse;
    logic [STEP_W-1:0] r_steps, n_steps;

    logic              homing;
    logic [STEP_W-1:0] seg_len;
    logic [STEP_W-1:0] steps_inc;
    logic              pulse;
    logic              release_c;
    logic [STA_W-1:0]  sta_next;
    t_status           status;

    // segment lookup
    assign homing    = (r_goal == '0) && (r_station == STA_W'(1));
    assign o_seg_idx = r_reverse ? (r_station - STA_W'(1)) : r_station;

    always_comb begin
        if (homing) begin
            seg_len = HOMING_STEPS;
        end else if (r_reverse && (r_station == '0)) begin
            seg_len = '0;
        end else begin
            seg_len = i_seg_data;
        end
    end

    assign sta_next = r_reverse ? (r_station - STA_W'(1)) : (r_station + STA_W'(1));

    always_comb begin
        n_moving  = r_moving;
        n_station = r_station;
        n_goal    = r_goal;
        n_reverse = r_reverse;
        n_steps   = r_steps;
        pulse     = 1'b0;
        release_c = 1'b0;
        status    = ST_OK;
        steps_inc = r_steps;
        case (t_action'(i_item.action))
            ACT_MOVE: begin
                if (r_moving) begin
                    status = ST_BUSY;
                end else if (i_item.target_station > STA_W'(NUM_SEGMENTS)) begin
                    status = ST_RANGE;
                end else begin
                    n_goal  = i_item.target_station;
                    n_steps = '0;
                    if (i_item.target_station == r_station) begin
                        release_c = 1'b1;
                    end else begin
                        n_reverse = r_station > i_item.target_station;
                        n_moving  = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                if (r_moving) begin
                    if (r_steps < seg_len) begin
                        pulse     = 1'b1;
                        steps_inc = r_steps + STEP_W'(1);
                    end
                    n_steps = steps_inc;
                    if (steps_inc >= seg_len) begin
                        n_steps   = '0;
                        n_station = sta_next;
                        if (sta_next == r_goal) begin
                            n_moving  = 1'b0;
                            release_c = 1'b1;
                        end
                    end
                end
            end
            ACT_BUMP: begin
                if (r_moving) begin
                    n_moving  = 1'b0;
                    n_station = '0;
                    n_steps   = '0;
                    release_c = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_tbl_wr.en   = i_advance && (t_action'(i_item.action) == ACT_WRITE)
                           && (i_item.table_index < STA_W'(NUM_SEGMENTS));
    assign o_tbl_wr.idx  = i_item.table_index;
    assign o_tbl_wr.data = i_item.segment_steps;

    assign o_res.step_pulse    = pulse;
    assign o_res.reverse_dir   = n_reverse;
    assign o_res.motor_release = release_c;
    assign o_res.station       = n_station;
    assign o_res.moving        = n_moving;
    assign o_res.status_code   = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving  <= 1'b0;
            r_station <= '0;
            r_goal    <= '0;
            r_reverse <= 1'b0;
            r_steps   <= '0;
        end else if (i_advance) begin
            r_moving  <= n_moving;
            r_station <= n_station;
            r_goal    <= n_goal;
            r_reverse <= n_reverse;
            r_steps   <= n_steps;
        end
    end

endmodule

>>> hw/rtl/stepper_station_positioner_unit.sv
// top level of the stepper station positioner: input register, control, result register
// depends on sspu_pkg, sspu_if, sspu_table and sspu_ctrl
//
// Each item (move, step tick, bump, table write) yields exactly one result item.
// An item is captured in an input register and resolved combinationally into the
// result register, so one item per cycle is sustained while results are taken; while
// a result waits, an empty input register still accepts one item and then stalls
// until the result is taken. Segment lengths come from a thirteen-entry table that
// resets to the default distances and can be rewritten at any time.
module stepper_station_positioner_unit
    import sspu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sspu_in_if.sink    i_in,
    sspu_out_if.source o_out
);

    logic              r_in_valid;
    t_item             r_item;
    logic              r_out_valid;
    t_result           r_res;
    logic              advance;
    t_result           res;
    t_tbl_wr           tbl_wr;
    logic [STA_W-1:0]  seg_idx;
    logic [STEP_W-1:0] seg_data;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.action         <= i_in.action;
            r_item.target_station <= i_in.target_station;
            r_item.table_index    <= i_in.table_index;
            r_item.segment_steps  <= i_in.segment_steps;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    sspu_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_idx  (seg_idx),
        .o_rd_data (seg_data)
    );

    sspu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_item     (r_item),
        .i_seg_data (seg_data),
        .o_seg_idx  (seg_idx),
        .o_tbl_wr   (tbl_wr),
        .o_res      (res)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.step_pulse    = r_res.step_pulse;
    assign o_out.reverse_dir   = r_res.reverse_dir;
    assign o_out.motor_release = r_res.motor_release;
    assign o_out.station       = r_res.station;
    assign o_out.moving        = r_res.moving;
    assign o_out.status_code   = r_res.status_code;

endmodule

>>> hw/rtl/sspu_checker.sv
// port-level assertions for the stepper station positioner
// depends on sspu_pkg; bound to stepper_station_positioner_unit
module sspu_checker
    import sspu_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_step_pulse,
    input logic             i_motor_release,
    input logic [STA_W-1:0] i_station,
    input logic             i_moving,
    input logic [1:0]       i_status_code
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // a rejected move neither steps nor releases
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status_code != ST_OK) |-> !i_step_pulse && !i_motor_release)
        else $error("rejected move caused motion");

    // release always ends the move
    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_motor_release |-> !i_moving)
        else $error("motor released while still moving");

    // carriage never beyond the last station
    a_station_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_station <= STA_W'(NUM_SEGMENTS)))
        else $error("station out of range");

endmodule

bind stepper_station_positioner_unit sspu_checker u_sspu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_step_pulse    (o_out.step_pulse),
    .i_motor_release (o_out.motor_release),
    .i_station       (o_out.station),
    .i_moving        (o_out.moving),
    .i_status_code   (o_out.status_code)
);

>>> tb/sspu_checker.sv
// scoreboard for the stepper station positioner: watches the item and result channels,
// predicts every result item from its own carriage model and compares them in order
// depends on sspu_pkg and the channel interfaces of sspu_if
module sspu_scoreboard
    import sspu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sspu_in_if   i_in,
    sspu_out_if  o_out,
    output int   o_errors,
    output int   o_pending,
    output logic o_moving,
    output int   o_checked,
    output int   o_pulses,
    output int   o_releases
);
    localparam int REPORT_LIMIT = 10;

    logic              carriage_moving;
    logic [STA_W-1:0]  carriage_station;
    logic [STA_W-1:0]  goal_station;
    logic              heading_reverse;
    logic [STEP_W-1:0] steps_in_segment;
    logic [STEP_W-1:0] segment_table [NUM_SEGMENTS];
    t_result           expected_results [$];
    int                error_count   = 0;
    int                checked_count = 0;
    int                pulse_count   = 0;
    int                release_count = 0;

    function automatic logic [STEP_W-1:0] segment_length();
        if (goal_station == '0 && carriage_station == STA_W'(1)) return HOMING_STEPS;
        if (heading_reverse) begin
            if (carriage_station == '0) return '0;
            return segment_table[carriage_station - 1'b1];
        end
        if (carriage_station >= NUM_SEGMENTS) return '0;
        return segment_table[carriage_station];
    endfunction

    task automatic predict_result(input t_item it);
        t_result           r;
        logic [STEP_W-1:0] len;
        r = '0;
        case (it.action)
            ACT_MOVE: begin
                if (carriage_moving) begin
                    r.status_code = ST_BUSY;
                end else if (it.target_station > NUM_SEGMENTS) begin
                    r.status_code = ST_RANGE;
                end else begin
                    goal_station     = it.target_station;
                    steps_in_segment = '0;
                    if (it.target_station == carriage_station) begin
                        r.motor_release = 1'b1;
                    end else begin
                        heading_reverse = carriage_station > it.target_station;
                        carriage_moving = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                if (carriage_moving) begin
                    len = segment_length();
                    if (steps_in_segment < len) begin
                        r.step_pulse     = 1'b1;
                        steps_in_segment = steps_in_segment + 1'b1;
                    end
                    if (steps_in_segment >= len) begin
                        steps_in_segment = '0;
                        carriage_station = heading_reverse ? carriage_station - 1'b1
                                                           : carriage_station + 1'b1;
                        if (carriage_station == goal_station) begin
                            carriage_moving = 1'b0;
                            r.motor_release = 1'b1;
                        end
                    end
                end
            end
            ACT_BUMP: begin
                if (carriage_moving) begin
                    carriage_moving  = 1'b0;
                    carriage_station = '0;
                    steps_in_segment = '0;
                    r.motor_release  = 1'b1;
                end
            end
            ACT_WRITE: begin
                if (it.table_index < NUM_SEGMENTS) segment_table[it.table_index] = it.segment_steps;
            end
        endcase
        r.reverse_dir = heading_reverse;
        r.station     = carriage_station;
        r.moving      = carriage_moving;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("[%0t] %s: expected pulse=%0b dir=%0b release=%0b station=%0d moving=%0b status=%0d",
                     $realtime, what, want.step_pulse, want.reverse_dir, want.motor_release,
                     want.station, want.moving, want.status_code);
            $display("    actual pulse=%0b dir=%0b release=%0b station=%0d moving=%0b status=%0d",
                     got.step_pulse, got.reverse_dir, got.motor_release, got.station,
                     got.moving, got.status_code);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   item;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            carriage_moving  = 1'b0;
            carriage_station = '0;
            goal_station     = '0;
            heading_reverse  = 1'b0;
            steps_in_segment = '0;
            segment_table    = SEG_DEFAULTS;
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                item = '{i_in.action, i_in.target_station, i_in.table_index, i_in.segment_steps};
                predict_result(item);
            end
            if (o_out.valid && o_out.ready) begin
                got = '{o_out.step_pulse, o_out.reverse_dir, o_out.motor_release, o_out.station,
                        o_out.moving, o_out.status_code};
                checked_count++;
                pulse_count   += got.step_pulse;
                release_count += got.motor_release;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no item waiting", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) report_mismatch("result mismatch", want, got);
                end
            end
        end
        o_errors   <= error_count;
        o_pending  <= expected_results.size();
        o_moving   <= carriage_moving;
        o_checked  <= checked_count;
        o_pulses   <= pulse_count;
        o_releases <= release_count;
    end

endmodule

>>> tb/tb_top.sv
// testbench top for stepper_station_positioner_unit: clock, reset, item stimulus with
// random idling on both channels, and the final verdict from the scoreboard's count
// depends on sspu_pkg, sspu_if, the block's RTL and sspu_scoreboard
module tb_top;
    import sspu_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_TAIL    = 300;
    localparam int DRAIN_CYCLES = 10;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    logic carriage_moving;
    int   items_sent  = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    int   errors;
    int   pending;
    int   checked;
    int   pulses;
    int   releases;

    sspu_in_if  in_ch ();
    sspu_out_if out_ch ();

    stepper_station_positioner_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sspu_scoreboard u_scoreboard (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_moving   (carriage_moving),
        .o_checked  (checked),
        .o_pulses   (pulses),
        .o_releases (releases)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 13);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_op(input t_action act, input logic [STA_W-1:0] tgt,
                           input logic [STA_W-1:0] idx, input logic [STEP_W-1:0] steps);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.action         <= act;
        in_ch.target_station <= tgt;
        in_ch.table_index    <= idx;
        in_ch.segment_steps  <= steps;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic tick();
        send_op(ACT_TICK, STA_W'($urandom_range(0, 15)), STA_W'($urandom_range(0, 15)),
                STEP_W'($urandom_range(0, 65535)));
    endtask

    task automatic bump();
        send_op(ACT_BUMP, STA_W'($urandom_range(0, 15)), STA_W'($urandom_range(0, 15)),
                STEP_W'($urandom_range(0, 65535)));
    endtask

    task automatic move_to(input logic [STA_W-1:0] tgt);
        send_op(ACT_MOVE, tgt, STA_W'($urandom_range(0, 15)), STEP_W'($urandom_range(0, 65535)));
    endtask

    task automatic write_seg(input logic [STA_W-1:0] idx, input logic [STEP_W-1:0] steps);
        send_op(ACT_WRITE, STA_W'($urandom_range(0, 15)), idx, steps);
    endtask

    function automatic logic [STEP_W-1:0] short_len();
        if ($urandom_range(0, 15) == 0) return STEP_W'($urandom_range(7, 300));
        return STEP_W'($urandom_range(0, 6));
    endfunction

    // tick until the carriage stops; the moving flag lags by one item
    task automatic travel(input int bump_after, input bit chatter);
        int ticks;
        ticks = 0;
        do begin
            if (bump_after != 0 && ticks >= bump_after) begin
                bump();
            end else if (chatter && $urandom_range(0, 29) == 0) begin
                move_to(STA_W'($urandom_range(0, 15)));
            end else if (chatter && $urandom_range(0, 29) == 0) begin
                write_seg(STA_W'($urandom_range(0, 15)), short_len());
            end else begin
                tick();
            end
            ticks++;
        end while (carriage_moving);
    endtask

    task automatic random_leg();
        int target;
        int bump_after;
        repeat ($urandom_range(0, 3)) begin
            write_seg(STA_W'($urandom_range(0, NUM_SEGMENTS - 1)), short_len());
        end
        case ($urandom_range(0, 9))
            0: tick();
            1: bump();
            2: write_seg(STA_W'($urandom_range(NUM_SEGMENTS, 15)),
                         STEP_W'($urandom_range(0, 65535)));
            default: ;
        endcase
        if ($urandom_range(0, 11) == 0) target = $urandom_range(NUM_SEGMENTS + 1, 15);
        else target = $urandom_range(0, NUM_SEGMENTS);
        if (target == 0) bump_after = $urandom_range(1, 150);
        else if ($urandom_range(0, 4) == 0) bump_after = $urandom_range(1, 40);
        else bump_after = 500;
        move_to(STA_W'(target));
        travel(bump_after, 1'b1);
    endtask

    initial begin
        int random_start;
        i_rst_n              <= 1'b0;
        calm                 <= 1'b1;
        in_ch.valid          <= 1'b0;
        in_ch.action         <= ACT_TICK;
        in_ch.target_station <= '0;
        in_ch.table_index    <= '0;
        in_ch.segment_steps  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle items, move to the current station, targets out of range
        tick();
        bump();
        move_to(STA_W'(0));
        move_to(STA_W'(NUM_SEGMENTS + 1));
        move_to(STA_W'(15));
        write_seg(STA_W'(NUM_SEGMENTS), 16'hFFFF);
        write_seg(STA_W'(14), 16'h0000);
        write_seg(STA_W'(15), 16'hFFFF);

        // first segment at its reset distance, then homing cut short by the bump switch
        move_to(STA_W'(1));
        travel(0, 1'b0);
        move_to(STA_W'(0));
        travel(300, 1'b0);

        calm <= 1'b0;
        write_seg(STA_W'(NUM_SEGMENTS - 1), 16'hFFFF);
        for (int i = 0; i < NUM_SEGMENTS; i++) write_seg(STA_W'(i), STEP_W'(i % 4));
        move_to(STA_W'(5));
        move_to(STA_W'(7));
        move_to(STA_W'(15));
        travel(3, 1'b0);
        move_to(STA_W'(2));
        travel(0, 1'b0);
        move_to(STA_W'(2));
        move_to(STA_W'(0));
        travel(20, 1'b0);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if (items_sent - random_start > RANDOM_ITEMS - CALM_TAIL) calm <= 1'b1;
            else calm <= ($urandom_range(0, 3) == 0);
            random_leg();
        end
        in_ch.valid <= 1'b0;
        calm        <= 1'b1;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("run covered %0d items and %0d checked results over %0d cycles",
                 items_sent, checked, cycle_count);
        $display("carriage issued %0d step pulses and %0d motor releases", pulses, releases);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sspu_pkg.sv
hw/rtl/sspu_if.sv
hw/rtl/sspu_table.sv
hw/rtl/sspu_ctrl.sv
hw/rtl/stepper_station_positioner_unit.sv
hw/rtl/sspu_checker.sv
tb/sspu_checker.sv
tb/tb_top.sv
